>>> src/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants of the fuzzy subsequence scorer
// Word formats, configuration indexes, end-of-text codes and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CHARS0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CHARS1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CHARS2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CHARS3 = 3'd4;

    localparam int QLEN_CFG_W = 6;
    localparam int QCHARS_W   = 256;
    localparam int OFFSET_W   = 10;
    localparam int SCORE_W    = 12;
    localparam int RUN_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int SLOT_W     = 6;
    localparam int LDIV_W     = 13;

    localparam logic [SCORE_W-1:0] SCORE_MAX     = 12'd4095;
    localparam logic [RUN_W-1:0]   RUN_MAX       = 6'd63;
    localparam logic [7:0]         BOUNDARY_ADD  = 8'd12;
    localparam logic [7:0]         RUN_BASE      = 8'd2;
    localparam logic [7:0]         RUN_STEP      = 8'd3;
    localparam logic [3:0]         PREFIX_BONUS  = 4'd8;

    localparam logic [1:0] END_EMPTY = 2'd0;
    localparam logic [1:0] END_FAIL  = 2'd1;
    localparam logic [1:0] END_OK    = 2'd2;

    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_SCORE  = 1'b1;

    typedef struct packed {
        logic [7:0] text_char;
        logic       char_present;
        logic       text_last;
    } text_t;

    typedef struct packed {
        logic                result_kind;
        logic [OFFSET_W-1:0] match_offset;
        logic [SCORE_W-1:0]  match_score;
        logic                run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               bank;
        logic [COUNT_W-1:0] count;
        logic [SCORE_W-1:0] sum;
        logic               prefix;
        logic [LDIV_W-1:0]  len_div;
    } desc_t;

    typedef struct packed {
        logic                en;
        logic                bank;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
    } mem_wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } release_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {8'h20, 8'h5F, 8'h2D, 8'h2F, 8'h2E, 8'h3A};
    endfunction

    function automatic logic [7:0] query_byte(input logic [QCHARS_W-1:0] chars,
                                              input logic [6:0] idx);
        logic [7:0] r;
        r = 8'd0;
        if (idx < 7'd32)
        begin
            r = chars[idx[4:0]*8 +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fss_queue.sv
// ----------------------------------------------------------------------------
// fss_queue: two-entry descriptor queue
// Carries end-of-text descriptors from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fss_pkg::desc_t push_data,
    input  wire logic           pop,
    output fss_pkg::desc_t      head,
    output logic                empty,
    output logic                full
);

    fss_pkg::desc_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fss_front.sv
// ----------------------------------------------------------------------------
// fss_front: byte intake and running match state
// Holds the query, matches one text byte per cycle while not stalled, writes
// match offsets and posts an end-of-text descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_front
#(
    parameter int MAX_QUERY = 32,
    parameter int MAX_TEXT  = 1024
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [fss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 text_valid,
    output logic                                      text_stall,
    input  wire fss_pkg::text_t                       text_word,
    input  wire fss_pkg::release_t                    rel,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output fss_pkg::desc_t                            q_data,
    output fss_pkg::mem_wr_t                          mem_wr
);

    localparam int QPW = $clog2(MAX_QUERY + 1);
    localparam int LW  = $clog2(MAX_TEXT + 1);

    logic [fss_pkg::QLEN_CFG_W-1:0] qlen_cfg_reg;
    logic [fss_pkg::QCHARS_W-1:0]   qchars_reg;
    logic [QPW-1:0]                 qpos_reg;
    logic [QPW-1:0]                 qpos_next;
    logic [fss_pkg::RUN_W-1:0]      run_reg;
    logic [fss_pkg::RUN_W-1:0]      run_next;
    logic                           boundary_reg;
    logic                           boundary_next;
    logic [fss_pkg::SCORE_W-1:0]    sum_reg;
    logic [fss_pkg::SCORE_W-1:0]    sum_next;
    logic [LW-1:0]                  len_reg;
    logic [LW-1:0]                  len_next;
    logic                           prefix_reg;
    logic                           prefix_next;
    logic                           bank_reg;
    logic                           bank_next;
    logic [1:0]                     busy_reg;
    logic [1:0]                     busy_next;

    logic [QPW-1:0]                 qlen;
    logic                           accept;
    logic                           take;
    logic [7:0]                     t;
    logic [7:0]                     qc;
    logic [7:0]                     qc0;
    logic                           active;
    logic                           hit;
    logic [7:0]                     add;
    logic [fss_pkg::SCORE_W:0]      sum_wide;
    logic [LW-1:0]                  pos;
    logic [QPW-1:0]                 qpos_upd;
    logic [fss_pkg::RUN_W-1:0]      run_upd;
    logic                           boundary_upd;
    logic [fss_pkg::SCORE_W-1:0]    sum_upd;
    logic [LW-1:0]                  len_upd;
    logic                           prefix_upd;

    always_comb
    begin
        if (int'(qlen_cfg_reg) > MAX_QUERY)
        begin
            qlen = QPW'(MAX_QUERY);
        end
        else
        begin
            qlen = QPW'(qlen_cfg_reg);
        end
    end

    assign text_stall = busy_reg[bank_reg] | q_full;
    assign accept     = text_valid & ~text_stall;
    assign take       = accept & text_word.char_present;

    always_comb
    begin
        t        = fss_pkg::fold(text_word.text_char);
        qc       = fss_pkg::fold(fss_pkg::query_byte(qchars_reg, 7'(qpos_reg)));
        qc0      = fss_pkg::fold(fss_pkg::query_byte(qchars_reg, 7'd0));
        active   = (qpos_reg < qlen);
        hit      = active && (t == qc);
        if (boundary_reg)
        begin
            add = fss_pkg::BOUNDARY_ADD;
        end
        else
        begin
            add = fss_pkg::RUN_BASE + 8'(run_reg) * fss_pkg::RUN_STEP;
        end
        sum_wide = {1'b0, sum_reg} + (fss_pkg::SCORE_W + 1)'(add);
        if (len_reg > LW'(MAX_TEXT - 1))
        begin
            pos = LW'(MAX_TEXT - 1);
        end
        else
        begin
            pos = len_reg;
        end

        qpos_upd     = qpos_reg;
        run_upd      = run_reg;
        boundary_upd = boundary_reg;
        sum_upd      = sum_reg;
        len_upd      = len_reg;
        prefix_upd   = prefix_reg;

        if (take)
        begin
            if ((len_reg == '0) && (qlen != '0) && (t == qc0))
            begin
                prefix_upd = 1'b1;
            end
            if (hit)
            begin
                qpos_upd     = qpos_reg + 1'b1;
                boundary_upd = 1'b0;
                if (sum_wide > (fss_pkg::SCORE_W + 1)'(fss_pkg::SCORE_MAX))
                begin
                    sum_upd = fss_pkg::SCORE_MAX;
                end
                else
                begin
                    sum_upd = sum_wide[fss_pkg::SCORE_W-1:0];
                end
                if (run_reg < fss_pkg::RUN_MAX)
                begin
                    run_upd = run_reg + 1'b1;
                end
            end
            else if (active)
            begin
                boundary_upd = fss_pkg::is_sep(t);
                run_upd      = '0;
            end
            if (len_reg < LW'(MAX_TEXT))
            begin
                len_upd = len_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        mem_wr.en     = take & hit;
        mem_wr.bank   = bank_reg;
        mem_wr.slot   = fss_pkg::SLOT_W'(qpos_reg);
        mem_wr.offset = fss_pkg::OFFSET_W'(pos);

        q_push         = accept & text_word.text_last;
        q_data.bank    = bank_reg;
        q_data.sum     = sum_upd;
        q_data.prefix  = prefix_upd;
        q_data.len_div = fss_pkg::LDIV_W'(len_upd >> 4);
        q_data.count   = '0;
        if (qlen == '0)
        begin
            q_data.kind = fss_pkg::END_EMPTY;
        end
        else if (qpos_upd < qlen)
        begin
            q_data.kind = fss_pkg::END_FAIL;
        end
        else
        begin
            q_data.kind  = fss_pkg::END_OK;
            q_data.count = fss_pkg::COUNT_W'(qpos_upd);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        bank_next = bank_reg;
        if (q_push)
        begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = ~bank_reg;
            qpos_next           = '0;
            run_next            = '0;
            boundary_next       = 1'b1;
            sum_next            = '0;
            len_next            = '0;
            prefix_next         = 1'b0;
        end
        else
        begin
            qpos_next     = qpos_upd;
            run_next      = run_upd;
            boundary_next = boundary_upd;
            sum_next      = sum_upd;
            len_next      = len_upd;
            prefix_next   = prefix_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_cfg_reg <= '0;
            qchars_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fss_pkg::CFG_QUERY_LENGTH: qlen_cfg_reg <= cfg_data[fss_pkg::QLEN_CFG_W-1:0];
                fss_pkg::CFG_QUERY_CHARS0: qchars_reg[63:0]    <= cfg_data;
                fss_pkg::CFG_QUERY_CHARS1: qchars_reg[127:64]  <= cfg_data;
                fss_pkg::CFG_QUERY_CHARS2: qchars_reg[191:128] <= cfg_data;
                fss_pkg::CFG_QUERY_CHARS3: qchars_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg     <= '0;
            run_reg      <= '0;
            boundary_reg <= 1'b1;
            sum_reg      <= '0;
            len_reg      <= '0;
            prefix_reg   <= 1'b0;
            bank_reg     <= 1'b0;
            busy_reg     <= 2'b00;
        end
        else
        begin
            qpos_reg     <= qpos_next;
            run_reg      <= run_next;
            boundary_reg <= boundary_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            prefix_reg   <= prefix_next;
            bank_reg     <= bank_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fss_back.sv
// ----------------------------------------------------------------------------
// fss_back: offset memory and result sequencer
// Finishes the score of a text, reads its offsets from the banked memory
// and delivers offset words followed by the score word.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_back
#(
    parameter int MAX_QUERY = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fss_pkg::mem_wr_t mem_wr,
    input  wire fss_pkg::desc_t   q_head,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output fss_pkg::release_t     rel,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output fss_pkg::result_t      result_word
);

    localparam int IDXW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

    logic [fss_pkg::OFFSET_W-1:0] mem [2][MAX_QUERY];
    logic [fss_pkg::OFFSET_W-1:0] mem_q_reg;

    logic                          cur_valid_reg;
    logic                          cur_valid_next;
    logic                          cur_bank_reg;
    logic [fss_pkg::COUNT_W-1:0]   cur_count_reg;
    logic [fss_pkg::SCORE_W-1:0]   cur_score_reg;
    logic [fss_pkg::COUNT_W-1:0]   issue_reg;
    logic [fss_pkg::COUNT_W-1:0]   issue_next;
    logic                          rd_pend_reg;
    logic                          rd_pend_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    fss_pkg::result_t              out_word_reg;
    fss_pkg::result_t              out_word_next;

    logic                          out_free;
    logic                          move;
    logic                          issue;
    logic                          finish;
    logic signed [14:0]            s_wide;
    logic [fss_pkg::SCORE_W-1:0]   score_new;

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    assign q_pop    = ~cur_valid_reg & ~q_empty;
    assign out_free = ~out_valid_reg | ~result_stall;
    assign move     = rd_pend_reg & out_free;
    assign issue    = cur_valid_reg & (issue_reg < cur_count_reg) & (~rd_pend_reg | move);
    assign finish   = cur_valid_reg & (issue_reg == cur_count_reg) & ~rd_pend_reg & out_free;

    assign rel.en   = finish;
    assign rel.bank = cur_bank_reg;

    always_comb
    begin
        s_wide = 15'(signed'({1'b0, q_head.sum}))
               + (q_head.prefix ? 15'(fss_pkg::PREFIX_BONUS) : 15'sd0)
               - 15'(signed'({1'b0, q_head.len_div}));
        case (q_head.kind)
            fss_pkg::END_EMPTY: score_new = 12'd1;
            fss_pkg::END_FAIL:  score_new = 12'd0;
            fss_pkg::END_OK:
            begin
                if (s_wide < 15'sd1)
                begin
                    score_new = 12'd1;
                end
                else if (s_wide > 15'(fss_pkg::SCORE_MAX))
                begin
                    score_new = fss_pkg::SCORE_MAX;
                end
                else
                begin
                    score_new = s_wide[fss_pkg::SCORE_W-1:0];
                end
            end
            default: score_new = 12'd0;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        issue_next     = issue_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            issue_next     = '0;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (issue)
        begin
            issue_next = issue_reg + 1'b1;
        end

        rd_pend_next = issue | (rd_pend_reg & ~move);

        out_valid_next = out_valid_reg & result_stall;
        out_word_next  = out_word_reg;
        if (move)
        begin
            out_valid_next             = 1'b1;
            out_word_next.result_kind  = fss_pkg::KIND_OFFSET;
            out_word_next.match_offset = mem_q_reg;
            out_word_next.match_score  = '0;
            out_word_next.run_last     = 1'b0;
        end
        else if (finish)
        begin
            out_valid_next             = 1'b1;
            out_word_next.result_kind  = fss_pkg::KIND_SCORE;
            out_word_next.match_offset = '0;
            out_word_next.match_score  = cur_score_reg;
            out_word_next.run_last     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.bank][mem_wr.slot[IDXW-1:0]] <= mem_wr.offset;
        end
        if (issue)
        begin
            mem_q_reg <= mem[cur_bank_reg][issue_reg[IDXW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (q_pop)
        begin
            cur_bank_reg  <= q_head.bank;
            cur_count_reg <= q_head.count;
            cur_score_reg <= score_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer: streamed fuzzy subsequence match scorer
// Scores a configured query against a text streamed one byte per word.
//
// Configuration: write query_length and the four query character words
// through cfg_write/cfg_index/cfg_data while no text is in flight.
// Input channel text_*: one text byte per word; text_last ends a text, and
// char_present low with text_last high ends a text without a byte.
// Output channel result_*: on a full match, one offset word per query
// character, then the score word with run_last high; otherwise the score
// word alone.
// Throughput: one text byte per cycle while text_stall is low. The front
// holds two offset banks, so it stalls only while two finished texts still
// wait to be delivered. A text's descriptor is registered in the queue and
// its score word in the output register; offset words also pass the memory
// read register and follow at one word per cycle while result_stall is low.
// Reset clears the query registers, the running state and the descriptor queue.
// A stalled receiver holds the output register; the front keeps taking
// bytes until both banks are claimed.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_subsequence_scorer
#(
    parameter int MAX_QUERY = 32,
    parameter int MAX_TEXT  = 1024
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            text_valid,
    output logic                                 text_stall,
    input  wire fss_pkg::text_t                  text_word,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output fss_pkg::result_t                     result_word
);

    fss_pkg::desc_t    q_data;
    fss_pkg::desc_t    q_head;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;
    fss_pkg::mem_wr_t  mem_wr;
    fss_pkg::release_t rel;

    fss_front
    #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_TEXT  (MAX_TEXT)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_word  (text_word),
        .rel        (rel),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data),
        .mem_wr     (mem_wr)
    );

    fss_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    fss_back
    #(
        .MAX_QUERY (MAX_QUERY)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .rel          (rel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

>>> src/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker: port-level checks of the result channel
// Watches result words for consistent fields and a quiet start after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_checker
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire fss_pkg::result_t result_word
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("stalled result word changed");

    a_offset_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.result_kind == fss_pkg::KIND_OFFSET)
        |-> (result_word.match_score == '0) && !result_word.run_last)
        else $error("offset word carries score or run_last");

    a_score_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.result_kind == fss_pkg::KIND_SCORE)
        |-> (result_word.match_offset == '0) && result_word.run_last)
        else $error("score word malformed");

    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);

`default_nettype wire
